[hw/rtl/assert_macros.svh]
// assertion macros shared by the port filter table rtl
// no dependencies; clock clk and active-low reset rst_n are taken from the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, checking suspended while reset is asserted
`define PBT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true at a clock edge
`define PBT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/pbt_pkg.sv]
// types and constants for the port filter table
// used by the channel interfaces, the table cells and the top level
package pbt_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int PORT_W      = 16;
    localparam int ACT_W       = 2;
    localparam int POS_W       = 6;
    localparam int STAT_W      = 2;
    localparam int CNT_W       = 6;

    // request codes
    typedef enum logic [ACT_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_RSVD   = 2'd3
    } action_t;

    // result codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_DUP    = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_COMMIT
    } state_t;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CMP,
        OP_APPEND,
        OP_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic              proto;
        logic [PORT_W-1:0] port;
    } cell_ctrl_t;

endpackage

[hw/rtl/pbt_if.sv]
// valid/ready channel interfaces for request and result beats
// depends on pbt_pkg for field widths
interface pbt_in_if import pbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic              protocol;
    logic [PORT_W-1:0] port;
    logic [POS_W-1:0]  position;

    modport source (output valid, action, protocol, port, position, input ready);
    modport sink   (input valid, action, protocol, port, position, output ready);
endinterface

interface pbt_out_if import pbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              hit;
    logic [CNT_W-1:0]  entry_count;

    modport source (output valid, status, hit, entry_count, input ready);
    modport sink   (input valid, status, hit, entry_count, output ready);
endinterface

[hw/rtl/pbt_cell.sv]
// one table slot: holds the tcp and udp port at this index and compares it
// depends on pbt_pkg; takes the next slot's entries for the remove shift
module pbt_cell import pbt_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [CW-1:0]     used,
    input  logic [CW-1:0]     first,
    input  logic [PORT_W-1:0] nbr_tcp,
    input  logic [PORT_W-1:0] nbr_udp,
    output logic [PORT_W-1:0] tcp,
    output logic [PORT_W-1:0] udp,
    output logic              match
);

    localparam logic [CW:0] IDX_X  = (CW+1)'(IDX);
    localparam logic [CW:0] IDX_X1 = (CW+1)'(IDX + 1);

    logic [PORT_W-1:0] tcp_reg, tcp_next;
    logic [PORT_W-1:0] udp_reg, udp_next;
    logic              match_reg, match_next;
    logic [PORT_W-1:0] own_sel;
    logic [PORT_W-1:0] nbr_sel;
    logic [PORT_W-1:0] new_val;
    logic [CW:0]       used_x;
    logic [CW:0]       first_x;
    logic              live;
    logic              wr;

    assign used_x  = {1'b0, used};
    assign first_x = {1'b0, first};
    assign own_sel = ctrl.proto ? udp_reg : tcp_reg;
    assign nbr_sel = ctrl.proto ? nbr_udp : nbr_tcp;
    assign live    = IDX_X < used_x;

    // slot update for append and shift
    always_comb
    begin
        wr      = 1'b0;
        new_val = ctrl.port;
        case (ctrl.op)
            OP_APPEND:
            begin
                wr      = (IDX_X == used_x);
                new_val = ctrl.port;
            end
            OP_SHIFT:
            begin
                wr      = (IDX_X >= first_x) && (IDX_X1 < used_x);
                new_val = nbr_sel;
            end
            default:
            begin
                wr      = 1'b0;
                new_val = ctrl.port;
            end
        endcase
        tcp_next = (wr && !ctrl.proto) ? new_val : tcp_reg;
        udp_next = (wr &&  ctrl.proto) ? new_val : udp_reg;
    end

    // compare against the live entry of the selected table
    always_comb
    begin
        match_next = match_reg;
        if (ctrl.op == OP_CMP)
        begin
            match_next = live && (own_sel == ctrl.port);
        end
    end

    always_ff @(posedge clk)
    begin
        tcp_reg   <= tcp_next;
        udp_reg   <= udp_next;
        match_reg <= match_next;
    end

    assign tcp   = tcp_reg;
    assign udp   = udp_reg;
    assign match = match_reg;

endmodule

[hw/rtl/port_blocklist_table_top.sv]
// top level of the port filter table: sequencer, entry counts and a row of slot cells
// depends on pbt_pkg, pbt_if.sv, pbt_cell and assert_macros.svh
//
// usage
//   in_ch carries one request beat: action (lookup, add, remove), protocol
//   (tcp or udp table), port, and a 1-based position for remove.
//   out_ch returns exactly one result beat per request: status, hit and
//   the entry count of the selected table after the request.
//   a request passes the idle state, where it is accepted, a match state in
//   which every cell compares its entry with the port in parallel, and a
//   commit state that reduces the match bits, decides the status and updates
//   the cells. the result shows on out_ch on the cycle after commit; a new
//   request is taken only once the previous one has committed.
//   the next request is accepted while a result still waits on out_ch; a
//   commit waits only while the output register is still full, so a stalled
//   receiver holds back at most the request behind the waiting result.
//   reset clears both entry counts, the result valid and the sequencer; the
//   table entries are not cleared and are never read above the count.
`include "assert_macros.svh"

module port_blocklist_table_top import pbt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    pbt_in_if.sink    in_ch,
    pbt_out_if.source out_ch
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int EW = (CW > CNT_W) ? CW : CNT_W;

    state_t state_reg, state_next;

    // captured request
    logic [ACT_W-1:0]  act_reg;
    logic              proto_reg;
    logic [PORT_W-1:0] port_reg;
    logic [POS_W-1:0]  pos_reg;

    logic [CW-1:0] tcp_used_reg, tcp_used_next;
    logic [CW-1:0] udp_used_reg, udp_used_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] status_reg;
    logic              hit_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [PORT_W-1:0] cell_tcp [ENTRIES];
    logic [PORT_W-1:0] cell_udp [ENTRIES];
    logic [ENTRIES-1:0] match_vec;

    cell_ctrl_t ctrl;
    cell_op_t   upd_op;
    action_t    act;
    status_t    status;
    logic       hit;
    logic       found;
    logic       full;
    logic       badpos;
    logic       in_acc;
    logic       out_free;
    logic       commit;
    logic [CW-1:0] used_sel;
    logic [CW-1:0] used_new;
    logic [CW-1:0] rm_first;
    logic [PW-1:0] pos_x;
    logic [PW-1:0] used_x;
    logic [EW-1:0] cnt_x;

    assign act      = action_t'(act_reg);
    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign commit   = (state_reg == S_COMMIT) && out_free;
    assign used_sel = proto_reg ? udp_used_reg : tcp_used_reg;
    assign found    = |match_vec;
    assign full     = (used_sel == CW'(ENTRIES));
    assign pos_x    = PW'(pos_reg);
    assign used_x   = PW'(used_sel);
    assign badpos   = (used_sel == '0) || (pos_reg == '0) || (pos_x > used_x);
    assign rm_first = CW'(pos_x - PW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // decision on the reduced match result
    always_comb
    begin
        status   = ST_OK;
        hit      = 1'b0;
        upd_op   = OP_HOLD;
        used_new = used_sel;
        case (act)
            ACT_LOOKUP:
            begin
                hit = found;
            end
            ACT_ADD:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else if (found)
                begin
                    status = ST_DUP;
                end
                else
                begin
                    upd_op   = OP_APPEND;
                    used_new = used_sel + CW'(1);
                end
            end
            ACT_REMOVE:
            begin
                if (badpos)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    upd_op   = OP_SHIFT;
                    used_new = used_sel - CW'(1);
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ch.ready = 1'b0;
        ctrl.op     = OP_HOLD;
        ctrl.proto  = proto_reg;
        ctrl.port   = port_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            S_MATCH:
            begin
                ctrl.op = OP_CMP;
            end
            S_COMMIT:
            begin
                ctrl.op = commit ? upd_op : OP_HOLD;
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    // count and output register next values
    always_comb
    begin
        tcp_used_next  = tcp_used_reg;
        udp_used_next  = udp_used_reg;
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
            if (proto_reg)
            begin
                udp_used_next = used_new;
            end
            else
            begin
                tcp_used_next = used_new;
            end
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign cnt_x = EW'(used_new);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tcp_used_reg  <= '0;
            udp_used_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tcp_used_reg  <= tcp_used_next;
            udp_used_reg  <= udp_used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            act_reg   <= in_ch.action;
            proto_reg <= in_ch.protocol;
            port_reg  <= in_ch.port;
            pos_reg   <= in_ch.position;
        end
        if (commit)
        begin
            status_reg <= status;
            hit_reg    <= hit;
            count_reg  <= cnt_x[CNT_W-1:0];
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.hit         = hit_reg;
    assign out_ch.entry_count = count_reg;

    // row of slot cells, each fed by its upper neighbor; the last one by itself
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        logic [PORT_W-1:0] nbr_tcp;
        logic [PORT_W-1:0] nbr_udp;
        if (g == ENTRIES - 1)
        begin : g_last
            assign nbr_tcp = cell_tcp[g];
            assign nbr_udp = cell_udp[g];
        end
        else
        begin : g_mid
            assign nbr_tcp = cell_tcp[g+1];
            assign nbr_udp = cell_udp[g+1];
        end

        pbt_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .used    (used_sel),
            .first   (rm_first),
            .nbr_tcp (nbr_tcp),
            .nbr_udp (nbr_udp),
            .tcp     (cell_tcp[g]),
            .udp     (cell_udp[g]),
            .match   (match_vec[g])
        );
    end

    // checks
    `PBT_NEVER(a_cnt_range, (tcp_used_reg > CW'(ENTRIES)) || (udp_used_reg > CW'(ENTRIES)), "entry count above table size")
    `PBT_ASSERT(a_acc_match, in_acc |=> (state_reg == S_MATCH), "accepted beat did not start compare")
    `PBT_ASSERT(a_cnt_stable, !commit |=> ($stable(tcp_used_reg) && $stable(udp_used_reg)), "count changed outside commit")
    `PBT_ASSERT(a_add_inc, (commit && (upd_op == OP_APPEND) && !proto_reg) |=> (tcp_used_reg == $past(tcp_used_reg) + CW'(1)), "tcp add did not grow the table")

endmodule

[tb/testbench.sv]
// self-checking testbench for the tcp/udp port filter table
// depends on pbt_pkg, the pbt_in_if/pbt_out_if channels and port_blocklist_table_top
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pbt_pkg::*;

    localparam logic PROTO_TCP     = 1'b0;
    localparam logic PROTO_UDP     = 1'b1;
    localparam int   LONG_HOLD     = 120;
    localparam int   QUIET_LIMIT   = 2000;
    localparam int   DRAIN_SETTLE  = 6;
    localparam int   POOL_SIZE     = 40;
    localparam int   SEGMENTS      = 12;
    localparam int   SEG_BEATS     = 150;

    // weighting of the random request mix
    localparam int   MIX_FILL      = 0;
    localparam int   MIX_BALANCED  = 1;
    localparam int   MIX_DRAIN     = 2;

    typedef struct packed {
        status_t           status;
        logic              hit;
        logic [CNT_W-1:0]  entry_count;
    } table_result_t;

    logic clk;
    logic rst_n;

    pbt_in_if  req_ch ();
    pbt_out_if rsp_ch ();

    port_blocklist_table_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch),
        .out_ch (rsp_ch)
    );

    // shadow copy of both port lists, indexed by protocol
    logic [PORT_W-1:0] tab_mem [2][ENTRIES_DEF];
    int                tab_cnt [2];
    logic [PORT_W-1:0] port_pool [POOL_SIZE];

    table_result_t pending_results [$];
    int            fail_count;
    int            quiet_cycles;
    bit            tx_steady;
    bit            rx_steady;
    bit            long_hold_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // expected outcome of one request; updates the shadow lists
    function automatic table_result_t predict_table_op(action_t act, logic proto,
            logic [PORT_W-1:0] port, logic [POS_W-1:0] pos);
        table_result_t res;
        bit            listed;
        int            n;
        res.status = ST_OK;
        res.hit    = 1'b0;
        n          = tab_cnt[proto];
        listed     = 1'b0;
        for (int i = 0; i < n; i++)
            if (tab_mem[proto][i] == port)
                listed = 1'b1;
        case (act)
            ACT_LOOKUP:
                res.hit = listed;
            ACT_ADD:
            begin
                // full takes priority over duplicate
                if (n >= ENTRIES_DEF)
                    res.status = ST_FULL;
                else if (listed)
                    res.status = ST_DUP;
                else
                begin
                    tab_mem[proto][n] = port;
                    tab_cnt[proto]    = n + 1;
                end
            end
            ACT_REMOVE:
            begin
                if (n == 0 || pos == 0 || pos > n)
                    res.status = ST_BADPOS;
                else
                begin
                    for (int i = pos - 1; i < n - 1; i++)
                        tab_mem[proto][i] = tab_mem[proto][i + 1];
                    tab_cnt[proto] = n - 1;
                end
            end
            default:
                ;
        endcase
        res.entry_count = CNT_W'(tab_cnt[proto]);
        return res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic action_t pick_action(int mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                if (r < 60) return ACT_ADD;
                else if (r < 85) return ACT_LOOKUP;
                else if (r < 96) return ACT_REMOVE;
            MIX_DRAIN:
                if (r < 15) return ACT_ADD;
                else if (r < 40) return ACT_LOOKUP;
                else if (r < 96) return ACT_REMOVE;
            default:
                if (r < 35) return ACT_ADD;
                else if (r < 70) return ACT_LOOKUP;
                else if (r < 95) return ACT_REMOVE;
        endcase
        return ACT_RSVD;
    endfunction

    // ports drawn from the list itself, a small pool, or anywhere
    function automatic logic [PORT_W-1:0] pick_port(logic proto);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35 && tab_cnt[proto] > 0)
            return tab_mem[proto][$urandom_range(0, tab_cnt[proto] - 1)];
        if (r < 75)
            return port_pool[$urandom_range(0, POOL_SIZE - 1)];
        return PORT_W'($urandom);
    endfunction

    // mostly valid positions, plus zero and out of range
    function automatic logic [POS_W-1:0] pick_position(logic proto);
        int r;
        int n;
        n = tab_cnt[proto];
        r = $urandom_range(0, 99);
        if (r < 70 && n > 0)
            return POS_W'($urandom_range(1, n));
        if (r < 80)
            return '0;
        if (r < 90 && n < 63)
            return POS_W'($urandom_range(n + 1, 63));
        return POS_W'($urandom_range(0, 63));
    endfunction

    // offer one request beat, record its expected result once accepted
    task automatic send_request(action_t act, logic proto, logic [PORT_W-1:0] port,
            logic [POS_W-1:0] pos);
        int gap;
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.protocol <= proto;
        req_ch.port     <= port;
        req_ch.position <= pos;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pending_results.push_back(predict_table_op(act, proto, port, pos));
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    // field extremes, table separation, shifting and the duplicate and bad-position rejects
    task automatic test_directed();
        send_request(ACT_LOOKUP, PROTO_TCP, 16'h0000, 6'd0);
        send_request(ACT_REMOVE, PROTO_TCP, 16'h0000, 6'd1);
        send_request(ACT_ADD,    PROTO_TCP, 16'h0000, 6'd0);
        send_request(ACT_ADD,    PROTO_TCP, 16'hFFFF, 6'd63);
        send_request(ACT_ADD,    PROTO_TCP, 16'h0000, 6'd0);
        send_request(ACT_LOOKUP, PROTO_TCP, 16'hFFFF, 6'd0);
        send_request(ACT_LOOKUP, PROTO_UDP, 16'hFFFF, 6'd0);
        send_request(ACT_ADD,    PROTO_UDP, 16'hFFFF, 6'd0);
        send_request(ACT_ADD,    PROTO_TCP, 16'h1234, 6'd0);
        send_request(ACT_RSVD,   PROTO_TCP, 16'h1234, 6'd1);
        send_request(ACT_REMOVE, PROTO_TCP, 16'h0000, 6'd0);
        send_request(ACT_REMOVE, PROTO_TCP, 16'h0000, 6'd4);
        send_request(ACT_REMOVE, PROTO_TCP, 16'hFFFF, 6'd63);
        send_request(ACT_REMOVE, PROTO_TCP, 16'h0000, 6'd1);
        send_request(ACT_LOOKUP, PROTO_TCP, 16'h0000, 6'd0);
        send_request(ACT_LOOKUP, PROTO_TCP, 16'h1234, 6'd0);
        send_request(ACT_REMOVE, PROTO_TCP, 16'h0000, 6'd2);
        send_request(ACT_LOOKUP, PROTO_TCP, 16'h1234, 6'd0);
        send_request(ACT_ADD,    PROTO_TCP, 16'h1234, 6'd0);
        send_request(ACT_REMOVE, PROTO_UDP, 16'h0000, 6'd1);
        send_request(ACT_REMOVE, PROTO_UDP, 16'h0000, 6'd1);
        send_request(ACT_RSVD,   PROTO_UDP, 16'hFFFF, 6'd32);
        wait_drained();
    endtask

    // fill each list to capacity, hit the full cases, then empty it again
    task automatic test_full_list();
        logic proto;
        for (int p = 0; p < 2; p++)
        begin
            proto = p[0];
            while (tab_cnt[proto] < ENTRIES_DEF)
                send_request(ACT_ADD, proto, PORT_W'($urandom), POS_W'($urandom));
            send_request(ACT_ADD,    proto, PORT_W'($urandom), 6'd0);
            send_request(ACT_ADD,    proto, tab_mem[proto][0], 6'd0);
            send_request(ACT_LOOKUP, proto, tab_mem[proto][ENTRIES_DEF - 1], 6'd0);
            send_request(ACT_REMOVE, proto, 16'h0000, 6'd33);
            send_request(ACT_REMOVE, proto, 16'h0000, 6'd32);
            send_request(ACT_ADD,    proto, 16'hFFFF, 6'd0);
            send_request(ACT_REMOVE, proto, 16'h0000, 6'd16);
            while (tab_cnt[proto] > 0)
                send_request(ACT_REMOVE, proto, pick_port(proto),
                             POS_W'($urandom_range(1, tab_cnt[proto])));
            send_request(ACT_REMOVE, proto, 16'h0000, 6'd1);
        end
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        tx_steady     = 1'b1;
        long_hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
            send_request(pick_action(MIX_BALANCED), 1'($urandom), pick_port(PROTO_TCP),
                         pick_position(PROTO_TCP));
        tx_steady = 1'b0;
        wait_drained();
    endtask

    // random segments that cycle through filling, balanced and emptying mixes
    task automatic test_random();
        int      mix;
        logic    proto;
        action_t act;
        for (int i = 0; i < POOL_SIZE; i++)
            port_pool[i] = PORT_W'($urandom);
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            mix       = seg % 3;
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < SEG_BEATS; i++)
            begin
                proto = 1'($urandom);
                act   = pick_action(mix);
                send_request(act, proto, pick_port(proto), pick_position(proto));
            end
            if ($urandom_range(0, 2) == 0)
                wait_drained();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drained();
    endtask

    // receiver ready: random holds, plus one long hold on request
    initial
    begin : rx_ready_gen
        int hold;
        hold         = 0;
        rsp_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else if (hold == 0)
                hold = pick_gap(rx_steady);
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        table_result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, rsp_ch.hit);
                    fail_count++;
                end
                if (rsp_ch.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           rsp_ch.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // reset, then the tests in turn
    initial
    begin
        fail_count      = 0;
        quiet_cycles    = 0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        long_hold_req   = 1'b0;
        tab_cnt[0]      = 0;
        tab_cnt[1]      = 0;
        for (int p = 0; p < 2; p++)
            for (int i = 0; i < ENTRIES_DEF; i++)
                tab_mem[p][i] = '0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_LOOKUP;
        req_ch.protocol = PROTO_TCP;
        req_ch.port     = '0;
        req_ch.position = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_list();
        test_backpressure();
        test_random();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
